// ===== hdl/sef_pkg.sv =====
// Shared types, constants and register codes of the 3x3 sharpen and emboss filter.
package sef_pkg;

   // Build-time defaults and fixed field widths.
   localparam int SEF_MAX_WIDTH = 2048;
   localparam int SEF_REG_W     = 12;
   localparam int SEF_ROW_W     = 13;
   localparam int SEF_ADDR_W    = 4;
   localparam int SEF_DATA_W    = 32;
   localparam int SEF_WIN_N     = 6;

   // Luma weights in thousandths, and a reciprocal that divides by 1000 exactly
   // for every weighted sum of 8-bit channels (0 to 255000).
   localparam int SEF_LUMA_R     = 299;
   localparam int SEF_LUMA_G     = 587;
   localparam int SEF_LUMA_B     = 114;
   localparam int SEF_LUMA_SUM_W = 18;
   localparam int SEF_LUMA_RECIP = 268436;
   localparam int SEF_LUMA_SHIFT = 28;
   localparam int SEF_LUMA_PROD_W = 37;

   // Kernel constants.
   localparam int SEF_SHARPEN_CENTRE = 5;
   localparam int SEF_EMBOSS_CORNER  = 2;
   localparam int SEF_EMBOSS_OFFSET  = 128;
   localparam int SEF_PIX_MAX        = 255;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_KIND   = 2'd2
   } reg_index_type;

   typedef enum logic {
      KIND_SHARPEN = 1'b0,
      KIND_EMBOSS  = 1'b1
   } kind_type;

   typedef enum logic {
      MODE_PIXEL = 1'b0,
      MODE_DRAIN = 1'b1
   } mode_type;

   // Red sits in the lowest byte, matching the stream data layout.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   // A stored pixel keeps its luma next to the colour so it is worked out once.
   typedef struct packed {
      logic [7:0] luma;
      rgb_type    rgb;
   } pix_type;

   // Per-item control carried alongside the pixel into the kernel stage.
   typedef struct packed {
      logic emit;
      logic apply;
      logic last;
   } ctl_type;

endpackage

// ===== hdl/sharpen_emboss_3x3_filter.sv =====
// Top level of the streaming 3x3 sharpen and emboss filter with line buffers.
//
//  Channel   Direction  Handshake            Contents
//  req_*     in         tvalid/tready        one pixel or drain tick per transfer
//  rsp_*     out        tvalid/tready/tlast  one filtered pixel per transfer
//  csr_*     in         APB setup/access     width, height and filter kind
//
// One input transfer is taken in every cycle while results are being taken; the
// rate is set by the single read port of each line buffer, which is read once per
// item. A result is registered in the first stage and then in the result register.
// Reset clears the position counters, the drain count and both valid flags at once;
// the line buffers and the window are not cleared and need no clearing pass.
// When a result waits, one more item is still taken into the first stage; only
// then does req_tready fall until the result has been transferred.
module sharpen_emboss_3x3_filter #(
   parameter int MAX_WIDTH = sef_pkg::SEF_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: pixel_red [7:0], pixel_green [15:8], pixel_blue [23:16]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,
   // req_tuser: mode [0]
   input  logic                            req_tuser,
   // rsp_tdata: out_red [7:0], out_green [15:8], out_blue [23:16]; rsp_tlast: frame_end
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sef_pkg::SEF_ADDR_W-1:0]  csr_paddr,
   input  logic [sef_pkg::SEF_DATA_W-1:0]  csr_pwdata,
   output logic [sef_pkg::SEF_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import sef_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   // Wide enough for the width register and for the drain length of width plus one.
   localparam int WW = ($clog2(MAX_WIDTH + 2) > SEF_REG_W) ? $clog2(MAX_WIDTH + 2)
                                                            : SEF_REG_W;

   // ---------------------------------------------------------------- registers
   logic [SEF_REG_W-1:0] width_ff;
   logic [SEF_REG_W-1:0] height_ff;
   kind_type             kind_ff;
   logic                 cfg_write;
   logic                 cfg_clear;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         REG_WIDTH:  cfg_clear = cfg_write;
         REG_HEIGHT: cfg_clear = cfg_write;
         REG_KIND:   cfg_clear = cfg_write;
         default:    cfg_clear = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SEF_REG_W'(640);
         height_ff <= SEF_REG_W'(480);
         kind_ff   <= KIND_SHARPEN;
      end else if (cfg_write) begin
         case (csr_paddr[3:2])
            REG_WIDTH:  width_ff  <= csr_pwdata[SEF_REG_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[SEF_REG_W-1:0];
            REG_KIND:   kind_ff   <= kind_type'(csr_pwdata[0]);
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_WIDTH:  csr_prdata = SEF_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = SEF_DATA_W'(height_ff);
         REG_KIND:   csr_prdata = SEF_DATA_W'(kind_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // A width of zero behaves as one and anything above the buffer depth is capped;
   // a height of zero behaves as one.
   logic [WW-1:0]        w_eff;
   logic [SEF_REG_W-1:0] h_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (WW'(width_ff) > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      h_eff = (height_ff == '0) ? SEF_REG_W'(1) : height_ff;
   end

   // ---------------------------------------------------------- frame position
   logic [XW-1:0]        col_ff, col_in;
   logic [SEF_ROW_W-1:0] row_ff, row_in;
   logic [WW-1:0]        pend_ff, pend_in;
   logic                 draining;
   logic                 req_xfer;
   logic                 take;
   logic [WW-1:0]        col_next;
   logic                 wrap;
   logic [SEF_ROW_W-1:0] row_next;
   logic [WW-1:0]        pend_dec;

   assign draining = (pend_ff != '0);
   assign req_xfer = req_tvalid & req_tready;
   // Drain ticks outside a drain are taken and dropped without trace.
   assign take     = req_xfer & (draining | (req_tuser == MODE_PIXEL));
   assign col_next = WW'(col_ff) + WW'(1);
   assign wrap     = (col_next >= w_eff);
   assign row_next = wrap ? row_ff + SEF_ROW_W'(1) : row_ff;
   assign pend_dec = pend_ff - WW'(1);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (cfg_clear) begin
         col_in  = '0;
         row_in  = '0;
         pend_in = '0;
      end else if (take) begin
         col_in = wrap ? '0 : col_next[XW-1:0];
         row_in = row_next;
         if (!draining) begin
            // The last pixel of the frame starts a drain of one row plus one pixel.
            if (wrap && (row_next >= SEF_ROW_W'(h_eff))) begin
               pend_in = w_eff + WW'(1);
            end
         end else begin
            pend_in = pend_dec;
            if (pend_dec == '0) begin
               col_in = '0;
               row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

   // ------------------------------------------------------ input luma and flags
   logic [SEF_LUMA_SUM_W-1:0]  luma_sum;
   logic [SEF_LUMA_PROD_W-1:0] luma_prod;
   pix_type                    in_pix;
   ctl_type                    in_ctl;

   always_comb begin
      luma_sum  = SEF_LUMA_SUM_W'(SEF_LUMA_R * int'(req_tdata[7:0]))
                + SEF_LUMA_SUM_W'(SEF_LUMA_G * int'(req_tdata[15:8]))
                + SEF_LUMA_SUM_W'(SEF_LUMA_B * int'(req_tdata[23:16]));
      luma_prod = SEF_LUMA_PROD_W'(luma_sum) * SEF_LUMA_PROD_W'(SEF_LUMA_RECIP);
      // During a drain the incoming data is replaced by a black pixel.
      if (draining) begin
         in_pix = '0;
      end else begin
         in_pix.luma = luma_prod[SEF_LUMA_SHIFT +: 8];
         in_pix.rgb  = rgb_type'(req_tdata);
      end
      in_ctl.emit  = (row_ff >= SEF_ROW_W'(2)) || ((row_ff == SEF_ROW_W'(1)) && (col_ff != '0));
      in_ctl.apply = (col_ff >= XW'(2)) && (row_ff >= SEF_ROW_W'(2))
                   && (h_eff >= SEF_REG_W'(3)) && (row_ff < SEF_ROW_W'(h_eff));
      in_ctl.last  = draining && (pend_dec == '0);
   end

   // ------------------------------------------------------------ first stage
   logic          s1_valid_ff;
   ctl_type       s1_ctl_ff;
   logic [XW-1:0] s1_col_ff;
   pix_type       s1_pix_ff;
   logic          s1_adv;
   logic          rsp_valid_ff;

   assign s1_adv     = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_ctl_ff <= in_ctl;
         s1_col_ff <= col_ff;
         s1_pix_ff <= in_pix;
      end
   end

   // ------------------------------------------------------------ line buffers
   // Each buffer is read at the column of the item entering the first stage and
   // written at the column of the item leaving it. Both meet at one address only
   // for one-pixel rows and after the end of a drain; the data being written is then passed straight on.
   pix_type older_mem [MAX_WIDTH];
   pix_type newer_mem [MAX_WIDTH];
   pix_type older_rd_ff, newer_rd_ff;
   logic    fwd_ff;
   pix_type fwd_older_ff, fwd_newer_ff;
   pix_type a_pix, b_pix;

   assign a_pix = fwd_ff ? fwd_older_ff : older_rd_ff;
   assign b_pix = fwd_ff ? fwd_newer_ff : newer_rd_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         older_rd_ff <= older_mem[col_ff];
      end
      if (s1_adv) begin
         older_mem[s1_col_ff] <= b_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         newer_rd_ff <= newer_mem[col_ff];
      end
      if (s1_adv) begin
         newer_mem[s1_col_ff] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (take) begin
         fwd_ff <= s1_adv && (s1_col_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         fwd_older_ff <= b_pix;
         fwd_newer_ff <= s1_pix_ff;
      end
   end

   // ----------------------------------------------------------------- window
   // Left column (entries 0 to 2) and middle column (3 to 5), each top to bottom.
   pix_type win_ff [SEF_WIN_N];

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= a_pix;
         win_ff[4] <= b_pix;
         win_ff[5] <= s1_pix_ff;
      end
   end

   // ----------------------------------------------------- kernel and result
   rgb_type kern_rgb;

   sef_kernel u_kernel (
      .window_pix (win_ff),
      .right_mid  (b_pix),
      .right_bot  (s1_pix_ff),
      .kind       (kind_ff),
      .ctl        (s1_ctl_ff),
      .result     (kern_rgb)
   );

   rgb_type rsp_data_ff;
   logic    rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_ctl_ff.emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= kern_rgb;
         rsp_last_ff <= s1_ctl_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/sef_kernel.sv =====
// Combinational 3x3 sharpen and emboss kernel with clamping and border bypass.
module sef_kernel (
   input  sef_pkg::pix_type window_pix [sef_pkg::SEF_WIN_N],
   input  sef_pkg::pix_type right_mid,
   input  sef_pkg::pix_type right_bot,
   input  sef_pkg::kind_type kind,
   input  sef_pkg::ctl_type ctl,
   output sef_pkg::rgb_type result
);
   import sef_pkg::*;

   // Window layout: 0..2 are the left column top to bottom, 3..5 the middle one.
   function automatic logic signed [11:0] ext(input logic [7:0] v);
      return $signed({4'b0000, v});
   endfunction

   function automatic logic [7:0] clamp8(input logic signed [11:0] v);
      logic [7:0] r;
      if (v < 12'sd0) begin
         r = 8'd0;
      end else if (v > 12'(SEF_PIX_MAX)) begin
         r = 8'(SEF_PIX_MAX);
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   function automatic logic [7:0] sharpen(input logic [7:0] mm, input logic [7:0] mt,
                                          input logic [7:0] mb, input logic [7:0] lm,
                                          input logic [7:0] rm);
      logic signed [11:0] s;
      s = ext(mm) * 12'(SEF_SHARPEN_CENTRE) - ext(mt) - ext(mb) - ext(lm) - ext(rm);
      return clamp8(s);
   endfunction

   logic signed [11:0] emboss_sum;
   logic [7:0]         emboss_val;

   always_comb begin
      emboss_sum = ext(window_pix[4].luma) + ext(right_mid.luma) + ext(window_pix[5].luma)
                 + ext(right_bot.luma) * 12'(SEF_EMBOSS_CORNER)
                 - ext(window_pix[0].luma) * 12'(SEF_EMBOSS_CORNER)
                 - ext(window_pix[3].luma) - ext(window_pix[1].luma)
                 + 12'(SEF_EMBOSS_OFFSET);
      emboss_val = clamp8(emboss_sum);
   end

   always_comb begin
      result = window_pix[4].rgb;
      if (ctl.apply) begin
         case (kind)
            KIND_SHARPEN: begin
               result.red   = sharpen(window_pix[4].rgb.red, window_pix[3].rgb.red,
                                      window_pix[5].rgb.red, window_pix[1].rgb.red,
                                      right_mid.rgb.red);
               result.green = sharpen(window_pix[4].rgb.green, window_pix[3].rgb.green,
                                      window_pix[5].rgb.green, window_pix[1].rgb.green,
                                      right_mid.rgb.green);
               result.blue  = sharpen(window_pix[4].rgb.blue, window_pix[3].rgb.blue,
                                      window_pix[5].rgb.blue, window_pix[1].rgb.blue,
                                      right_mid.rgb.blue);
            end
            KIND_EMBOSS: begin
               result.red   = emboss_val;
               result.green = emboss_val;
               result.blue  = emboss_val;
            end
            default: begin
               result = window_pix[4].rgb;
            end
         endcase
      end
   end

endmodule

// ===== hdl/sef_checker.sv =====
// Port-level checks of the 3x3 sharpen and emboss filter, bound to its top level.
module sef_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A waiting result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before its transfer");

   // A waiting result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Reset leaves no result on offer.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   // The input only stalls when a finished result is held back downstream.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a blocked result");

endmodule

bind sharpen_emboss_3x3_filter sef_checker u_sef_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the streaming 3x3 sharpen and emboss filter.
module tb;
   import sef_pkg::*;

   // Timing budget. SETTLE_CYCLES covers the pipeline after the last result,
   // since the final pixels of an aborted frame may still be in flight without
   // ever producing a transfer on the result side.
   localparam int SETTLE_CYCLES  = 8;
   localparam int FINAL_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int MAX_REPORTS    = 10;
   localparam int PARTIAL_PIXELS = 40;

   // One expected result: the filtered pixel and the frame end marker.
   typedef struct packed {
      logic    last;
      rgb_type px;
   } filtered_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [SEF_ADDR_W-1:0] csr_paddr = '0;
   logic [SEF_DATA_W-1:0] csr_pwdata = '0;
   logic [SEF_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Expected results in arrival order, and the error bookkeeping.
   filtered_pixel_type expected_pixels[$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 items_taken = 0;

   // Rates for the two sides, in percent of cycles.
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // The receiver owns its hold-off counter; a test asks for a long hold by
   // bumping hold_request, which the receiver notices on the next edge.
   int hold_request = 0;
   int hold_served  = 0;
   int hold_left    = 0;

   // Set when a frame was left unfinished, so the next frame must start with a
   // register write that aborts it.
   bit reconfigure_due = 1'b0;

   // Our own copy of the filter state and its registers.
   rgb_type      line_older[SEF_MAX_WIDTH];
   rgb_type      line_newer[SEF_MAX_WIDTH];
   rgb_type      window_px[SEF_WIN_N];
   int unsigned  col_pos;
   int unsigned  row_pos;
   int unsigned  drain_left;
   logic [11:0]  cfg_width  = 12'd640;
   logic [11:0]  cfg_height = 12'd480;
   kind_type     cfg_kind   = KIND_SHARPEN;

   sharpen_emboss_3x3_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // A run that never finishes is a failure in its own right.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random stalls at stall_pct, or a solid hold-off when asked.
   always @(posedge clock) begin
      if (hold_request != hold_served) begin
         hold_served <= hold_request;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // A width of zero acts as one and anything beyond the line buffers is cut
   // back to their depth; a height of zero acts as one.
   function automatic int active_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > SEF_MAX_WIDTH) return SEF_MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic int active_height();
      return (cfg_height == 0) ? 1 : int'(cfg_height);
   endfunction

   function automatic logic [7:0] clamp_level(int v);
      if (v < 0) return 8'd0;
      if (v > SEF_PIX_MAX) return 8'd255;
      return v[7:0];
   endfunction

   // Integer luma, truncated towards zero.
   function automatic int luma_of(rgb_type p);
      return (SEF_LUMA_R * int'(p.red) + SEF_LUMA_G * int'(p.green)
              + SEF_LUMA_B * int'(p.blue)) / 1000;
   endfunction

   function automatic logic [7:0] sharpen_level(int mid, int up, int down, int left,
                                                int right);
      return clamp_level(SEF_SHARPEN_CENTRE * mid - up - down - left - right);
   endfunction

   // Advances the filter by one accepted transfer and queues the result it
   // causes, if any. The window holds the left column in entries 0 to 2 and
   // the middle column in 3 to 5, top to bottom; the right column is made of
   // the two line buffer reads and the incoming pixel.
   task automatic predict_filter(mode_type mode, rgb_type in_px);
      int                 w;
      int                 h;
      int unsigned        x;
      int unsigned        y;
      int                 lum;
      bit                 draining;
      bit                 emit;
      rgb_type            fresh;
      rgb_type            above;
      rgb_type            beside;
      filtered_pixel_type result;

      w = active_width();
      h = active_height();
      draining = (drain_left != 0);
      // A drain tick while pixels are still due is ignored altogether.
      if (!draining && mode == MODE_DRAIN) return;
      items_taken++;
      if (col_pos >= w) col_pos = 0;
      // A pixel that arrives during the drain only counts as a tick.
      fresh = draining ? '0 : in_px;
      x = col_pos;
      y = row_pos;
      above  = line_older[x];
      beside = line_newer[x];
      line_older[x] = beside;
      line_newer[x] = fresh;

      emit = (y >= 2) || (y == 1 && x >= 1);
      result.px   = window_px[4];
      result.last = 1'b0;
      // Only interior pixels are filtered; the border passes straight through.
      if (emit && x >= 2 && y >= 2 && h >= 3 && y - 1 <= h - 2) begin
         if (cfg_kind == KIND_SHARPEN) begin
            result.px.red   = sharpen_level(window_px[4].red, window_px[3].red,
                                            window_px[5].red, window_px[1].red,
                                            beside.red);
            result.px.green = sharpen_level(window_px[4].green, window_px[3].green,
                                            window_px[5].green, window_px[1].green,
                                            beside.green);
            result.px.blue  = sharpen_level(window_px[4].blue, window_px[3].blue,
                                            window_px[5].blue, window_px[1].blue,
                                            beside.blue);
         end else begin
            lum = -SEF_EMBOSS_CORNER * luma_of(window_px[0]) - luma_of(window_px[3])
                  - luma_of(window_px[1]) + luma_of(window_px[4]) + luma_of(beside)
                  + luma_of(window_px[5]) + SEF_EMBOSS_CORNER * luma_of(fresh);
            result.px.red   = clamp_level(lum + SEF_EMBOSS_OFFSET);
            result.px.green = result.px.red;
            result.px.blue  = result.px.red;
         end
      end

      window_px[0] = window_px[3];
      window_px[1] = window_px[4];
      window_px[2] = window_px[5];
      window_px[3] = above;
      window_px[4] = beside;
      window_px[5] = fresh;

      x++;
      if (x >= w) begin
         x = 0;
         y++;
      end
      col_pos = x;
      row_pos = y;

      // Once the last row is in, the frame owes one row plus one pixel of
      // ticks to push the remaining results out.
      if (!draining) begin
         if (x == 0 && y >= h) drain_left = w + 1;
      end else begin
         drain_left--;
         if (drain_left == 0) begin
            result.last = 1'b1;
            col_pos = 0;
            row_pos = 0;
         end
      end

      if (emit) expected_pixels.push_back(result);
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic note_mismatch(string what, filtered_pixel_type want,
                                filtered_pixel_type got);
      if (mismatch_count < MAX_REPORTS)
         $display("mismatch (%s) at cycle %0d: expected rgb %h last %b, got rgb %h last %b",
                  what, cycle_count, want.px, want.last, got.px, got.last);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      filtered_pixel_type want;
      filtered_pixel_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.px   = rsp_tdata;
         got.last = rsp_tlast;
         if (expected_pixels.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
         end else begin
            want = expected_pixels.pop_front();
            if (got.px.red !== want.px.red || got.px.green !== want.px.green ||
                got.px.blue !== want.px.blue || got.last !== want.last)
               note_mismatch("wrong field", want, got);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Channel levels lean towards the rails so that clamping is hit often.
   function automatic logic [7:0] rand_level();
      case ($urandom_range(3))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic rgb_type rand_pixel();
      rgb_type p;
      p.red   = rand_level();
      p.green = rand_level();
      p.blue  = rand_level();
      return p;
   endfunction

   function automatic rgb_type grey(logic [7:0] level);
      rgb_type p;
      p.red   = level;
      p.green = level;
      p.blue  = level;
      return p;
   endfunction

   // Offers one item and waits for its transfer. Valid stays high into the
   // next item unless the sender decides to idle for a while.
   task automatic send_item(mode_type mode, rgb_type px);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      predict_filter(mode, px);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_random_pixels(int count);
      for (int i = 0; i < count; i++) send_item(MODE_PIXEL, rand_pixel());
   endtask

   // Drain ticks; some of them are sent as pixels, which the block must treat
   // as ticks all the same.
   task automatic send_drain(int count, int pixel_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < pixel_pct) send_item(MODE_PIXEL, rand_pixel());
         else send_item(MODE_DRAIN, rand_pixel());
      end
   endtask

   // Stops offering and waits until every expected result has been taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
   endtask

   // Register write over the APB port, only ever done with the block idle.
   task automatic csr_write(reg_index_type index, logic [31:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SEF_ADDR_W'(int'(index) * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (index)
         REG_WIDTH:  cfg_width  = value[11:0];
         REG_HEIGHT: cfg_height = value[11:0];
         REG_KIND:   cfg_kind   = kind_type'(value[0]);
         default: ;
      endcase
      // Any register write throws away the frame in progress.
      col_pos    = 0;
      row_pos    = 0;
      drain_left = 0;
   endtask

   task automatic configure(int width, int height, kind_type kind);
      csr_write(REG_WIDTH, 32'(width));
      csr_write(REG_HEIGHT, 32'(height));
      csr_write(REG_KIND, 32'(kind));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-made frames that push red to the upper rail and green to the lower
   // rail in sharpen mode, and the luma to both rails in emboss mode. A drain
   // tick in mid-frame must be ignored and a pixel among the drain ticks counts as a tick.
   task automatic test_kernel_rails();
      rgb_type     centre;
      rgb_type     edge_px;
      logic [11:0] white_map;
      send_idle_pct = 0;
      stall_pct     = 0;
      centre.red    = 8'd255;
      centre.green  = 8'd0;
      centre.blue   = 8'd128;
      edge_px.red   = 8'd0;
      edge_px.green = 8'd255;
      edge_px.blue  = 8'd100;
      configure(3, 3, KIND_SHARPEN);
      for (int i = 0; i < 9; i++) begin
         if (i == 5) send_item(MODE_DRAIN, rand_pixel());
         if (i == 4) send_item(MODE_PIXEL, centre);
         else if (i % 2 == 1) send_item(MODE_PIXEL, edge_px);
         else send_item(MODE_PIXEL, rand_pixel());
      end
      send_item(MODE_DRAIN, rand_pixel());
      send_item(MODE_DRAIN, rand_pixel());
      send_item(MODE_PIXEL, rand_pixel());
      send_item(MODE_DRAIN, rand_pixel());

      // Rows 0,0,W,W / 0,W,W,0 / W,W,0,0: the left interior pixel saturates
      // high and the right one low.
      white_map = 12'b0011_0110_1100;
      configure(4, 3, KIND_EMBOSS);
      for (int i = 0; i < 12; i++)
         send_item(MODE_PIXEL, grey(white_map[11 - i] ? 8'd255 : 8'd0));
      send_drain(5, 0);
   endtask

   // Width zero and height zero, then the start of a line wider than the
   // buffers and of the tallest frame; both are broken off by the next
   // register write.
   task automatic test_size_extremes();
      send_idle_pct = 0;
      stall_pct     = 0;
      configure(0, 0, KIND_SHARPEN);
      send_random_pixels(1);
      send_drain(active_width() + 1, 0);
      configure(4095, 3, KIND_SHARPEN);
      send_random_pixels(PARTIAL_PIXELS);
      configure(1, 4095, KIND_EMBOSS);
      send_random_pixels(PARTIAL_PIXELS);
      reconfigure_due = 1'b1;
   endtask

   // A frame cut short by a register write, then a full frame afterwards.
   task automatic test_frame_abort();
      send_idle_pct = 27;
      stall_pct     = 27;
      configure(5, 4, KIND_SHARPEN);
      send_random_pixels(12);
      csr_write(REG_KIND, 32'(KIND_EMBOSS));
      send_random_pixels(active_width() * active_height());
      send_drain(active_width() + 1, 0);
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering, so the pipeline fills and the block must stall its input.
   task automatic test_receiver_hold();
      send_idle_pct = 0;
      stall_pct     = 0;
      configure(8, 8, KIND_SHARPEN);
      hold_request <= hold_request + 1;
      send_random_pixels(active_width() * active_height());
      send_drain(active_width() + 1, 0);
   endtask

   // One random frame. Mostly well-formed with random content; now and then a
   // stray drain tick, a pause until all results are in, or a frame that is
   // broken off and aborted by the next register write.
   task automatic run_random_frame();
      int w;
      int h;
      int pixels;
      bit broken;
      if (reconfigure_due || $urandom_range(99) < 60) begin
         case ($urandom_range(19))
            0:       w = 0;
            1:       w = $urandom_range(13, 40);
            default: w = $urandom_range(1, 12);
         endcase
         case ($urandom_range(19))
            0:       h = 0;
            1:       h = $urandom_range(9, 20);
            default: h = $urandom_range(1, 8);
         endcase
         // Upper data bits are random; only the low bits are register contents.
         csr_write(REG_WIDTH, 32'(w) | ($urandom() & 32'hFFFF_F000));
         csr_write(REG_HEIGHT, 32'(h) | ($urandom() & 32'hFFFF_F000));
         csr_write(REG_KIND, 32'($urandom_range(1)) | ($urandom() & 32'hFFFF_FFFE));
         reconfigure_due = 1'b0;
      end
      pixels = active_width() * active_height();
      broken = ($urandom_range(99) < 8);
      if (broken) pixels = $urandom_range(pixels);
      for (int i = 0; i < pixels; i++) begin
         if ($urandom_range(99) < 4) send_item(MODE_DRAIN, rand_pixel());
         if ($urandom_range(99) < 3) wait_drained();
         send_item(MODE_PIXEL, rand_pixel());
      end
      if (broken) reconfigure_due = 1'b1;
      else send_drain(active_width() + 1, 10);
   endtask

   task automatic test_random_traffic(int idle_pct, int stall, int item_count);
      int target;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      target        = items_taken + item_count;
      while (items_taken < target) run_random_frame();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      col_pos    = 0;
      row_pos    = 0;
      drain_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_kernel_rails();
      test_size_extremes();
      test_frame_abort();
      test_receiver_hold();
      test_random_traffic(0, 0, 105);
      test_random_traffic(67, 0, 105);
      test_random_traffic(0, 67, 105);
      test_random_traffic(27, 27, 105);

      // Let every outstanding result arrive, then watch for stragglers.
      stall_pct = 0;
      wait_drained();
      repeat (FINAL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
